>>> sv/hlo_pkg.sv
`default_nettype none

package hlo_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_RED      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_GREEN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BLUE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_STEP   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_DIAGONAL = 3'd6;

    // Fixed-point constants of the sine and cosine table.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ANGLE_CODES = 256;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  radius_index;
        logic [7:0]  angle_index;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  gray;
    } hlo_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       on_line;
    } hlo_out_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [7:0]  line_red;
        logic [7:0]  line_green;
        logic [7:0]  line_blue;
        logic [19:0] radius_step;
        logic [20:0] half_diagonal;
    } hlo_cfg_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ADD,
        CMD_PIXEL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [9:0]         radius_index;
        logic [7:0]         angle;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic [7:0]         gray;
    } hlo_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD_MUL,
        BK_ADD_WR,
        BK_SCAN,
        BK_DRAIN,
        BK_RESULT
    } bk_state_t;

endpackage

`default_nettype wire

>>> sv/hough_line_overlay.sv
`default_nettype none

// Draws up to MAX_LINES stored Hough lines over a gray image. Items on the s_ channel
// clear the line table, add a line (radius bin and angle bin; dropped once the table
// is full) or carry a pixel, and every pixel gives one transfer on the m_ channel:
// the line colour when some stored line passes within half a pixel of it, otherwise
// its gray level on all three channels. Items go through a two-entry queue into a
// single line tester that reads the line table one entry per cycle through a
// pipeline of table read, trig lookup, multiply, error and compare. Configuration
// writes are taken at any time on the cfg_ channel but should only be made while
// no items are in flight.
module hough_line_overlay #(
    parameter int MAX_LINES  = 16,
    parameter int ANGLE_BINS = 180
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire hlo_pkg::hlo_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output hlo_pkg::hlo_out_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hlo_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [hlo_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hlo_pkg::*;

    hlo_cfg_t cfg_reg;
    logic     q_push, q_full, q_pop, q_not_empty;
    hlo_cmd_t q_push_data, q_pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{frame_width: 13'd256, frame_height: 13'd256,
                         line_red: 8'd0, line_green: 8'd0, line_blue: 8'd0,
                         radius_step: 20'd256, half_diagonal: 21'd46341};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data[12:0];
                CFG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data[12:0];
                CFG_LINE_RED:      cfg_reg.line_red      <= cfg_data[7:0];
                CFG_LINE_GREEN:    cfg_reg.line_green    <= cfg_data[7:0];
                CFG_LINE_BLUE:     cfg_reg.line_blue     <= cfg_data[7:0];
                CFG_RADIUS_STEP:   cfg_reg.radius_step   <= cfg_data[19:0];
                CFG_HALF_DIAGONAL: cfg_reg.half_diagonal <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    hlo_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_push  (q_push),
        .q_data  (q_push_data),
        .q_full  (q_full)
    );

    hlo_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    hlo_back #(
        .MAX_LINES  (MAX_LINES),
        .ANGLE_BINS (ANGLE_BINS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> sv/hlo_front.sv
`default_nettype none

module hlo_front (
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hlo_pkg::hlo_in_t  s_data,
    input  wire hlo_pkg::hlo_cfg_t cfg,
    output logic                  q_push,
    output hlo_pkg::hlo_cmd_t     q_data,
    input  wire logic             q_full
);
    import hlo_pkg::*;

    logic keep;

    // Unknown kinds are taken and dropped here so the back never sees them.
    always_comb begin
        keep = 1'b0;
        q_data.op = CMD_CLEAR;
        case (s_data.kind)
            KIND_CLEAR: begin
                keep = 1'b1;
                q_data.op = CMD_CLEAR;
            end
            KIND_ADD: begin
                keep = 1'b1;
                q_data.op = CMD_ADD;
            end
            KIND_PIXEL: begin
                keep = 1'b1;
                q_data.op = CMD_PIXEL;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        q_data.radius_index = s_data.radius_index;
        q_data.angle        = s_data.angle_index;
        // Offsets from the image centre, with y pointing up.
        q_data.dx   = $signed({1'b0, s_data.pixel_x}) - $signed({1'b0, cfg.frame_width[12:1]});
        q_data.dy   = $signed({1'b0, cfg.frame_height[12:1]}) - $signed({1'b0, s_data.pixel_y});
        q_data.gray = s_data.gray;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

`default_nettype wire

>>> sv/hlo_queue.sv
`default_nettype none

module hlo_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire hlo_pkg::hlo_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output hlo_pkg::hlo_cmd_t      pop_data,
    output logic                   not_empty
);
    import hlo_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    hlo_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = slot_reg[rd_ptr_reg];
    assign full      = (fill_reg == FW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);

endmodule

`default_nettype wire

>>> sv/hlo_back.sv
`default_nettype none

module hlo_back #(
    parameter int MAX_LINES  = 16,
    parameter int ANGLE_BINS = 180
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hlo_pkg::hlo_cfg_t cfg,
    input  wire logic              q_valid,
    input  wire hlo_pkg::hlo_cmd_t q_data,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hlo_pkg::hlo_out_t      m_data
);
    import hlo_pkg::*;

    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LINES);
    localparam logic signed [39:0] E_LIMIT = 40'sd2097152;
    localparam logic signed [31:0] RADIUS_MAX = 32'sd8388607;
    localparam logic signed [31:0] RADIUS_MIN = -32'sd8388608;

    typedef struct packed {
        logic signed [23:0] radius;
        logic [7:0]         angle;
    } line_entry_t;

    // Cosine and sine per angle code in Q2.14, worked out at elaboration.
    logic signed [15:0] cos_rom [ANGLE_CODES];
    logic signed [15:0] sin_rom [ANGLE_CODES];

    for (genvar b = 0; b < ANGLE_CODES; b++) begin : g_trig
        localparam logic [63:0] BIN_MOD = 64'(b) % 64'(2 * ANGLE_BINS);
        localparam logic [63:0] QUAD    = (64'd2 * BIN_MOD) / 64'(ANGLE_BINS);
        localparam logic [63:0] EXC     = (64'd2 * BIN_MOD) % 64'(ANGLE_BINS);
        localparam bit          SWAP    = (64'd2 * EXC) > 64'(ANGLE_BINS);
        localparam logic [63:0] EFOLD   = SWAP ? (64'(ANGLE_BINS) - EXC) : EXC;
        localparam logic [63:0] PHI     =
            (EFOLD * HALF_PI_Q30 + 64'(ANGLE_BINS / 2)) / 64'(ANGLE_BINS);
        localparam logic [63:0] X2      = (PHI * PHI) >> 30;
        // Taylor series in Horner form; divisors are (2k)(2k+1) and (2k-1)(2k).
        localparam logic [63:0] S1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 64'd110;
        localparam logic [63:0] S2 = Q30_ONE - ((X2 * S1) >> 30) / 64'd72;
        localparam logic [63:0] S3 = Q30_ONE - ((X2 * S2) >> 30) / 64'd42;
        localparam logic [63:0] S4 = Q30_ONE - ((X2 * S3) >> 30) / 64'd20;
        localparam logic [63:0] S5 = Q30_ONE - ((X2 * S4) >> 30) / 64'd6;
        localparam logic [63:0] SV = (PHI * S5) >> 30;
        localparam logic [63:0] C1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 64'd132;
        localparam logic [63:0] C2 = Q30_ONE - ((X2 * C1) >> 30) / 64'd90;
        localparam logic [63:0] C3 = Q30_ONE - ((X2 * C2) >> 30) / 64'd56;
        localparam logic [63:0] C4 = Q30_ONE - ((X2 * C3) >> 30) / 64'd30;
        localparam logic [63:0] C5 = Q30_ONE - ((X2 * C4) >> 30) / 64'd12;
        localparam logic [63:0] CV = Q30_ONE - ((X2 * C5) >> 30) / 64'd2;
        localparam logic [63:0] CR = (CV + 64'd32768) >> 16;
        localparam logic [63:0] SR = (SV + 64'd32768) >> 16;
        localparam logic signed [15:0] CA = 16'(SWAP ? SR : CR);
        localparam logic signed [15:0] SA = 16'(SWAP ? CR : SR);
        localparam logic [1:0] QS = QUAD[1:0];

        assign cos_rom[b] = (QS == 2'd0) ? CA : (QS == 2'd1) ? -SA :
                            (QS == 2'd2) ? -CA : SA;
        assign sin_rom[b] = (QS == 2'd0) ? SA : (QS == 2'd1) ? CA :
                            (QS == 2'd2) ? -SA : -CA;
    end

    bk_state_t          state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    hlo_cmd_t           cmd_reg, cmd_next;
    logic               hit_reg;
    logic               hit_clr;
    logic               rd_en, wr_en, out_load;

    logic [29:0]        prod_reg;
    logic signed [31:0] radius_full;
    logic signed [23:0] radius_sat;

    line_entry_t        line_mem [MAX_LINES];
    line_entry_t        rd_entry_reg;

    logic               p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [23:0] rad2_reg, rad3_reg;
    logic signed [28:0] px_reg, py_reg;
    logic signed [39:0] e_reg;

    logic               m_valid_reg;
    hlo_out_t           out_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        cmd_next    = cmd_reg;
        hit_clr     = 1'b0;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_ADD: begin
                            // A full table drops the new line.
                            if (count_reg != FULL_COUNT) begin
                                state_next = BK_ADD_MUL;
                            end
                        end
                        CMD_PIXEL: begin
                            hit_clr     = 1'b1;
                            rd_idx_next = '0;
                            state_next  = (count_reg == '0) ? BK_RESULT : BK_SCAN;
                        end
                        default: begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_ADD_MUL: begin
                state_next = BK_ADD_WR;
            end
            BK_ADD_WR: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = BK_IDLE;
            end
            BK_SCAN: begin
                rd_en       = 1'b1;
                rd_idx_next = rd_idx_reg + AW'(1);
                if (CW'(rd_idx_reg) + CW'(1) == count_reg) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!(p1_vld_reg || p2_vld_reg || p3_vld_reg || p4_vld_reg)) begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        prod_reg <= 30'(cmd_reg.radius_index) * 30'(cfg.radius_step);
    end

    // The radius can never reach the lower bound, but both ends are clamped.
    always_comb begin
        radius_full = $signed({2'b00, prod_reg}) - $signed({11'd0, cfg.half_diagonal});
        if (radius_full > RADIUS_MAX) begin
            radius_sat = 24'sh7FFFFF;
        end else if (radius_full < RADIUS_MIN) begin
            radius_sat = 24'sh800000;
        end else begin
            radius_sat = radius_full[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[count_reg[AW-1:0]] <= '{radius: radius_sat, angle: cmd_reg.angle};
        end
        if (rd_en) begin
            rd_entry_reg <= line_mem[rd_idx_reg];
        end
    end

    // Line test pipeline: table read, trig lookup, products, error, compare.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            p1_vld_reg <= rd_en;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            if (hit_clr) begin
                hit_reg <= 1'b0;
            end else if (p4_vld_reg && (e_reg < E_LIMIT) && (e_reg > -E_LIMIT)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cos_reg  <= cos_rom[rd_entry_reg.angle];
        sin_reg  <= sin_rom[rd_entry_reg.angle];
        rad2_reg <= rd_entry_reg.radius;
        px_reg   <= 29'(cmd_reg.dx) * 29'(cos_reg);
        py_reg   <= 29'(cmd_reg.dy) * 29'(sin_reg);
        rad3_reg <= rad2_reg;
        e_reg    <= (40'(rad3_reg) <<< 14) - ((40'(px_reg) + 40'(py_reg)) <<< 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (hit_reg) begin
                out_reg <= '{red: cfg.line_red, green: cfg.line_green,
                             blue: cfg.line_blue, on_line: 1'b1};
            end else begin
                out_reg <= '{red: cmd_reg.gray, green: cmd_reg.gray,
                             blue: cmd_reg.gray, on_line: 1'b0};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import hlo_pkg::*;

    localparam int          CLK_PERIOD    = 20;
    localparam int          MAX_LINES     = 16;
    localparam int          ANGLE_BINS    = 180;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 250;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    typedef enum int {
        RX_OPEN,
        RX_BUSY_LIGHT,
        RX_BUSY_HEAVY,
        RX_EVERY_FOURTH
    } rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    hlo_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    hlo_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the block: settings, line table and the pixels still owed.
    hlo_cfg_t   cfg_shadow = '{frame_width: 13'd256, frame_height: 13'd256,
                               line_red: 8'd0, line_green: 8'd0, line_blue: 8'd0,
                               radius_step: 20'd256, half_diagonal: 21'd46341};
    longint     stored_radius [MAX_LINES];
    logic [7:0] stored_angle [MAX_LINES];
    int         stored_lines = 0;
    hlo_out_t   pending_pixels [$];

    int          mismatches  = 0;
    int unsigned cycles_run  = 0;
    bit          sender_gaps = 1'b1;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    rx_mode_t    rx_mode     = RX_OPEN;
    int          mode_left   = 0;
    int unsigned rx_tick     = 0;
    hlo_out_t    exp_pix;

    hough_line_overlay i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Cosine and sine of an angle bin in Q2.14, from a Q30 Taylor series.
    function automatic void angle_cos_sin(input logic [7:0] bin, output longint cos_q14,
                                          output longint sin_q14);
        int unsigned       sin_div [5] = '{110, 72, 42, 20, 6};
        int unsigned       cos_div [5] = '{132, 90, 56, 30, 12};
        int unsigned       m, quad, e;
        bit                swap;
        longint unsigned   phi, x2, t, sv, cv;
        longint            c, s, tmp;
        m    = bin % (2 * ANGLE_BINS);
        quad = (2 * m) / ANGLE_BINS;
        e    = (2 * m) % ANGLE_BINS;
        swap = 1'b0;
        if (2 * e > ANGLE_BINS) begin
            e    = ANGLE_BINS - e;
            swap = 1'b1;
        end
        phi = (64'(e) * HALF_PI_Q30 + 64'(ANGLE_BINS / 2)) / 64'(ANGLE_BINS);
        x2  = (phi * phi) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / sin_div[i];
        end
        sv = (phi * t) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / cos_div[i];
        end
        cv = Q30_ONE - ((x2 * t) >> 30) / 2;
        c = longint'((cv + 64'd32768) >> 16);
        s = longint'((sv + 64'd32768) >> 16);
        if (swap) begin
            tmp = c;
            c   = s;
            s   = tmp;
        end
        case (quad & 3)
            0: begin cos_q14 = c;  sin_q14 = s;  end
            1: begin cos_q14 = -s; sin_q14 = c;  end
            2: begin cos_q14 = -c; sin_q14 = -s; end
            default: begin cos_q14 = s; sin_q14 = -c; end
        endcase
    endfunction

    // Q8 radius of a bin, saturated to the signed 24-bit range of the table.
    function automatic longint bin_radius(logic [9:0] ri);
        longint v, step, hd;
        v    = longint'(ri);
        step = longint'(cfg_shadow.radius_step);
        hd   = longint'(cfg_shadow.half_diagonal);
        v    = v * step - hd;
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v;
    endfunction

    function automatic bit pixel_on_any_line(hlo_in_t item);
        longint dx, dy, c, s, err;
        dx = longint'(item.pixel_x);
        dx = dx - longint'(cfg_shadow.frame_width >> 1);
        dy = longint'(cfg_shadow.frame_height >> 1);
        dy = dy - longint'(item.pixel_y);
        for (int i = 0; i < stored_lines; i++) begin
            angle_cos_sin(stored_angle[i], c, s);
            err = stored_radius[i] * 16384 - (dx * c + dy * s) * 256;
            if (err < 0) err = -err;
            if (err < 64'sd2097152) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Updates the shadow table for one accepted transfer and, for a pixel, queues its expected output.
    task automatic overlay_predict(input hlo_in_t item);
        hlo_out_t pix;
        case (item.kind)
            KIND_CLEAR: stored_lines = 0;
            KIND_ADD: begin
                if (stored_lines < MAX_LINES) begin
                    stored_radius[stored_lines] = bin_radius(item.radius_index);
                    stored_angle[stored_lines]  = item.angle_index;
                    stored_lines++;
                end
            end
            KIND_PIXEL: begin
                if (pixel_on_any_line(item)) begin
                    pix.red     = cfg_shadow.line_red;
                    pix.green   = cfg_shadow.line_green;
                    pix.blue    = cfg_shadow.line_blue;
                    pix.on_line = 1'b1;
                end else begin
                    pix.red     = item.gray;
                    pix.green   = item.gray;
                    pix.blue    = item.gray;
                    pix.on_line = 1'b0;
                end
                pending_pixels.push_back(pix);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel: r=%0d g=%0d b=%0d on_line=%0d",
                             m_data.red, m_data.green, m_data.blue, m_data.on_line);
                end
            end else begin
                exp_pix = pending_pixels.pop_front();
                if (m_data.red !== exp_pix.red || m_data.green !== exp_pix.green ||
                    m_data.blue !== exp_pix.blue || m_data.on_line !== exp_pix.on_line) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("pixel mismatch: expected r=%0d g=%0d b=%0d on_line=%0d, %s",
                                 exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.on_line,
                                 $sformatf("got r=%0d g=%0d b=%0d on_line=%0d", m_data.red,
                                           m_data.green, m_data.blue, m_data.on_line));
                    end
                end
            end
        end
    end

    // Result side: changing stall patterns, plus a long hold-off on request.
    always @(negedge aclk) begin
        rx_tick++;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:         m_ready <= 1'b1;
                RX_BUSY_LIGHT:   m_ready <= ($urandom_range(0, 3) != 0);
                RX_BUSY_HEAVY:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_EVERY_FOURTH: m_ready <= (rx_tick % 4 == 0);
                default:         m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_item(input hlo_in_t item);
        @(negedge aclk);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        overlay_predict(item);
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        // Adds and clears give no transfer, so allow for their tail as well.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:   cfg_shadow.frame_width   = val[12:0];
            CFG_FRAME_HEIGHT:  cfg_shadow.frame_height  = val[12:0];
            CFG_LINE_RED:      cfg_shadow.line_red      = val[7:0];
            CFG_LINE_GREEN:    cfg_shadow.line_green    = val[7:0];
            CFG_LINE_BLUE:     cfg_shadow.line_blue     = val[7:0];
            CFG_RADIUS_STEP:   cfg_shadow.radius_step   = val[19:0];
            CFG_HALF_DIAGONAL: cfg_shadow.half_diagonal = val[20:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input int w, input int h, input int red, input int green,
                                  input int blue, input int step, input int hd);
        wait_until_drained();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_LINE_RED, CFG_DATA_W'(red));
        write_reg(CFG_LINE_GREEN, CFG_DATA_W'(green));
        write_reg(CFG_LINE_BLUE, CFG_DATA_W'(blue));
        write_reg(CFG_RADIUS_STEP, CFG_DATA_W'(step));
        write_reg(CFG_HALF_DIAGONAL, CFG_DATA_W'(hd));
    endtask

    function automatic hlo_in_t scrambled_item(logic [1:0] kind);
        logic [63:0] raw;
        hlo_in_t     item;
        raw       = {$urandom, $urandom};
        item      = raw[$bits(hlo_in_t)-1:0];
        item.kind = kind;
        return item;
    endfunction

    // Mostly bins whose radius falls within the configured diagonal.
    function automatic hlo_in_t line_item();
        hlo_in_t item;
        longint  lim;
        item = scrambled_item(KIND_ADD);
        if (cfg_shadow.radius_step != 0 && $urandom_range(0, 4) != 0) begin
            lim = 2 * longint'(cfg_shadow.half_diagonal) / cfg_shadow.radius_step + 1;
            if (lim > 1023) lim = 1023;
            item.radius_index = 10'($urandom_range(0, int'(lim)));
        end
        if ($urandom_range(0, 3) != 0) begin
            item.angle_index = 8'($urandom_range(0, ANGLE_BINS - 1));
        end
        return item;
    endfunction

    function automatic hlo_in_t pixel_in_frame();
        hlo_in_t item;
        item = scrambled_item(KIND_PIXEL);
        if ($urandom_range(0, 3) != 0) begin
            item.pixel_x = 12'($urandom_range(0, cfg_shadow.frame_width - 1));
            item.pixel_y = 12'($urandom_range(0, cfg_shadow.frame_height - 1));
        end
        return item;
    endfunction

    // A pixel on or next to a given line; falls back to random coordinates
    // when the line lies outside the 12-bit coordinate range.
    function automatic hlo_in_t pixel_near(longint radius, logic [7:0] angle);
        hlo_in_t item;
        longint  c, s, cx, cy, dx, dy, px, py, jit;
        item = scrambled_item(KIND_PIXEL);
        angle_cos_sin(angle, c, s);
        cx  = longint'(cfg_shadow.frame_width >> 1);
        cy  = longint'(cfg_shadow.frame_height >> 1);
        jit = $urandom_range(0, 2);
        if ((s < 0 ? -s : s) >= (c < 0 ? -c : c)) begin
            dx = $urandom_range(0, cfg_shadow.frame_width - 1);
            dx = dx - cx;
            dy = (radius * 64 - dx * c) / s;
            if ($urandom_range(0, 3) == 0) dy = dy + jit - 1;
        end else begin
            dy = $urandom_range(0, cfg_shadow.frame_height - 1);
            dy = dy - cy;
            dx = (radius * 64 - dy * s) / c;
            if ($urandom_range(0, 3) == 0) dx = dx + jit - 1;
        end
        px = dx + cx;
        py = cy - dy;
        if (px >= 0 && px <= 4095 && py >= 0 && py <= 4095) begin
            item.pixel_x = px[11:0];
            item.pixel_y = py[11:0];
        end
        return item;
    endfunction

    function automatic hlo_in_t pixel_near_stored();
        int j;
        if (stored_lines == 0) return pixel_in_frame();
        j = $urandom_range(0, stored_lines - 1);
        return pixel_near(stored_radius[j], stored_angle[j]);
    endfunction

    task automatic test_empty_table();
        hlo_in_t item;
        item = scrambled_item(KIND_PIXEL);
        item.pixel_x = 12'd0;
        item.pixel_y = 12'd0;
        item.gray    = 8'd0;
        send_item(item);
        item.pixel_x = 12'd4095;
        item.pixel_y = 12'd4095;
        item.gray    = 8'd255;
        send_item(item);
        send_item(scrambled_item(KIND_UNUSED));
        send_item(pixel_in_frame());
    endtask

    task automatic test_basic_lines();
        hlo_in_t item;
        apply_settings(256, 256, 255, 0, 128, 256, 46341);
        send_item(scrambled_item(KIND_CLEAR));
        // A vertical line through the centre column, then the widest bin at an
        // angle past half a turn, then the smallest bin on a horizontal line.
        item = scrambled_item(KIND_ADD);
        item.radius_index = 10'd181;
        item.angle_index  = 8'd0;
        send_item(item);
        item.radius_index = 10'd1023;
        item.angle_index  = 8'd255;
        send_item(item);
        item.radius_index = 10'd0;
        item.angle_index  = 8'd90;
        send_item(item);
        item = scrambled_item(KIND_PIXEL);
        item.pixel_x = 12'd128;
        item.pixel_y = 12'd0;
        item.gray    = 8'd0;
        send_item(item);
        item.pixel_y = 12'd4095;
        item.gray    = 8'd255;
        send_item(item);
        item.pixel_x = 12'd4095;
        item.pixel_y = 12'd0;
        send_item(item);
        for (int j = 0; j < 3; j++) begin
            send_item(pixel_near(stored_radius[j], stored_angle[j]));
        end
        send_item(scrambled_item(KIND_UNUSED));
        send_item(pixel_in_frame());
    endtask

    task automatic test_table_full();
        hlo_in_t extra;
        apply_settings(640, 480, 0, 255, 0, 256, (640 + 480) * 91);
        send_item(scrambled_item(KIND_CLEAR));
        repeat (MAX_LINES) send_item(line_item());
        // The table is full now, so this line must be dropped.
        extra = line_item();
        send_item(extra);
        send_item(pixel_near(bin_radius(extra.radius_index), extra.angle_index));
        send_item(pixel_near(stored_radius[MAX_LINES-1], stored_angle[MAX_LINES-1]));
        send_item(scrambled_item(KIND_CLEAR));
        send_item(pixel_near(stored_radius[0], stored_angle[0]));
        send_item(line_item());
        send_item(pixel_near_stored());
    endtask

    task automatic test_image_extremes();
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: apply_settings(2, 4096, 1, 2, 3, 0, 2097151);
                1: apply_settings(4096, 2, 255, 255, 255, 1048575, 0);
                default: apply_settings(301, 199, 17, 200, 99, 256, (301 + 199) * 91);
            endcase
            send_item(scrambled_item(KIND_CLEAR));
            repeat (2) send_item(line_item());
            repeat (2) send_item(pixel_near_stored());
            send_item(pixel_in_frame());
        end
    endtask

    task automatic test_backpressure();
        apply_settings(256, 256, 10, 20, 30, 256, 46341);
        send_item(scrambled_item(KIND_CLEAR));
        repeat (4) send_item(line_item());
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_item(i % 2 == 0 ? pixel_near_stored() : pixel_in_frame());
        end
        sender_gaps = 1'b1;
    endtask

    task automatic random_phase(input int n_items);
        int w, h, step, hd, sent, pick;
        case ($urandom_range(0, 4))
            0: w = 2;
            1: w = 4096;
            2: w = $urandom_range(2, 4096);
            3: w = $urandom_range(2, 64);
            default: w = 256 + $urandom_range(0, 1);
        endcase
        case ($urandom_range(0, 4))
            0: h = 2;
            1: h = 4096;
            2: h = $urandom_range(2, 4096);
            3: h = $urandom_range(2, 64);
            default: h = 256 + $urandom_range(0, 1);
        endcase
        case ($urandom_range(0, 7))
            0: step = 0;
            1: step = 1048575;
            2: step = $urandom_range(1, 1048575);
            3: step = $urandom_range(64, 1024);
            default: step = 256;
        endcase
        case ($urandom_range(0, 5))
            0: hd = 0;
            1: hd = 2097151;
            2: hd = $urandom_range(0, 2097151);
            default: hd = (w + h) * 91;
        endcase
        apply_settings(w, h, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), step, hd);
        sender_gaps = ($urandom_range(0, 3) != 0);
        send_item(scrambled_item(KIND_CLEAR));
        sent = $urandom_range(0, MAX_LINES + 2);
        repeat (sent) send_item(line_item());
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) send_item(scrambled_item(KIND_UNUSED));
            else begin
                if (pick < 7) send_item(scrambled_item(KIND_CLEAR));
                else if (pick < 14) send_item(line_item());
                else if (pick < 60) send_item(pixel_near_stored());
                else send_item(pixel_in_frame());
                sent++;
            end
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random();
        repeat (6) random_phase(50);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_basic_lines();
        test_table_full();
        test_image_extremes();
        test_backpressure();
        test_random();
        wait_until_drained();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
